// File: rtl/lkew_pkg.sv
// Shared types and constants for the link keepalive escalation watchdog.
`timescale 1ns / 1ps
`default_nettype none

package lkew_pkg;

  // Field widths
  localparam int unsigned TimeW     = 32;
  localparam int unsigned LimitW    = 17;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = LimitW;

  // Input word: uptime, list_empty, newest_live_time, fast_pair_active,
  // hold_released, clear_request, zero filled to whole bytes
  localparam int unsigned InFieldsW = 2 * TimeW + 4;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;

  // Output word: action, release_hold, zero filled to a byte
  localparam int unsigned OutFieldsW = 3;
  localparam int unsigned OutDataW   = 8;

  // Register reset values
  localparam logic              RoleIsApRst    = 1'b1;
  localparam logic [LimitW-1:0] ApSilenceRst   = LimitW'(1200);
  localparam logic [CountW-1:0] ApRebootRst    = CountW'(6);
  localparam logic [LimitW-1:0] CpeSilenceRst  = LimitW'(600);
  localparam logic [CountW-1:0] CpeRebootRst   = CountW'(6);
  localparam logic [CountW-1:0] FastHoldRst    = CountW'(180);

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_ROLE_IS_AP     = 3'd0,
    CFG_AP_SILENCE     = 3'd1,
    CFG_AP_REBOOT      = 3'd2,
    CFG_CPE_SILENCE    = 3'd3,
    CFG_CPE_REBOOT     = 3'd4,
    CFG_FAST_HOLD      = 3'd5
  } cfg_idx_e;

  // Action codes
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_RELOAD = 2'd1,
    ACT_REBOOT = 2'd2
  } act_e;

endpackage

`default_nettype wire

// File: rtl/link_keepalive_escalation_watchdog.sv
// Top level of the link keepalive escalation watchdog: tick register, decision logic, result register.
`timescale 1ns / 1ps
`default_nettype none

// One tick word per cycle while the result side takes words: the tick is captured in an input
// register, and the decision and the state update (silence timer, reload count, hold counter)
// are made from it and land in the result register. The only loop is the state update itself,
// which closes through the state registers alone, so a tick may be accepted every cycle while
// the result side takes words. Configuration writes take effect at the next edge and are meant
// for idle periods. action is 0 none, 1 reload wifi, 2 reboot device; release_hold asks that
// the fast pairing hold be released.
module link_keepalive_escalation_watchdog
  import lkew_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Tick stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [31:0] uptime_seconds, [32] list_empty, [64:33] newest_live_time,
  // [65] fast_pair_active, [66] hold_released, [67] clear_request, [71:68] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // Result stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [1:0] action, [2] release_hold, [7:3] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  // Configuration registers
  logic              role_is_ap_q;
  logic [LimitW-1:0] ap_silence_q;
  logic [CountW-1:0] ap_reboot_q;
  logic [LimitW-1:0] cpe_silence_q;
  logic [CountW-1:0] cpe_reboot_q;
  logic [CountW-1:0] fast_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_is_ap_q  <= RoleIsApRst;
      ap_silence_q  <= ApSilenceRst;
      ap_reboot_q   <= ApRebootRst;
      cpe_silence_q <= CpeSilenceRst;
      cpe_reboot_q  <= CpeRebootRst;
      fast_hold_q   <= FastHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ROLE_IS_AP:  role_is_ap_q  <= cfg_wdata_i[0];
        CFG_AP_SILENCE:  ap_silence_q  <= cfg_wdata_i;
        CFG_AP_REBOOT:   ap_reboot_q   <= cfg_wdata_i[CountW-1:0];
        CFG_CPE_SILENCE: cpe_silence_q <= cfg_wdata_i;
        CFG_CPE_REBOOT:  cpe_reboot_q  <= cfg_wdata_i[CountW-1:0];
        CFG_FAST_HOLD:   fast_hold_q   <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the input stage moves on when the result register frees up
  logic                   in_valid_q;
  logic [InFieldsW-1:0]   in_data_q;
  logic                   out_valid_q;
  logic [OutFieldsW-1:0]  out_data_q;
  logic                   advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Capture the tick word
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i[InFieldsW-1:0];
    end
  end

  // Unpack the registered tick
  logic [TimeW-1:0] now;
  logic             list_empty;
  logic [TimeW-1:0] newest;
  logic             fast_active;
  logic             released;
  logic             clear_req;

  assign now         = in_data_q[TimeW-1:0];
  assign list_empty  = in_data_q[TimeW];
  assign newest      = in_data_q[2*TimeW:TimeW+1];
  assign fast_active = in_data_q[2*TimeW+1];
  assign released    = in_data_q[2*TimeW+2];
  assign clear_req   = in_data_q[2*TimeW+3];

  // Watchdog state
  logic [TimeW-1:0]  last_act_q, last_act_d;
  logic [CountW-1:0] reload_cnt_q, reload_cnt_d;
  logic [CountW-1:0] hold_cnt_q, hold_cnt_d;
  act_e              action;
  logic              release_hold;

  // Role thresholds and silence arithmetic
  logic [LimitW-1:0] limit;
  logic [CountW-1:0] boot;
  logic [TimeW-1:0]  last_base;
  logic [TimeW-1:0]  quiet;
  logic [CountW-1:0] reload_inc;

  assign limit      = role_is_ap_q ? ap_silence_q : cpe_silence_q;
  assign boot       = role_is_ap_q ? ap_reboot_q : cpe_reboot_q;
  assign last_base  = (last_act_q == '0) ? now : last_act_q;
  assign quiet      = now - last_base;
  assign reload_inc = reload_cnt_q + CountW'(1);

  // Decide the tick
  always_comb begin
    last_act_d   = last_act_q;
    reload_cnt_d = reload_cnt_q;
    hold_cnt_d   = hold_cnt_q;
    action       = ACT_NONE;
    release_hold = 1'b0;
    if (clear_req) begin
      last_act_d   = '0;
      reload_cnt_d = '0;
    end else begin
      last_act_d = last_base;
      if (fast_active && !released) begin
        // hold pairing: count ticks, release past the limit
        if (hold_cnt_q > fast_hold_q) begin
          release_hold = 1'b1;
          hold_cnt_d   = CountW'(1);
        end else begin
          hold_cnt_d = hold_cnt_q + CountW'(1);
        end
      end else begin
        hold_cnt_d = '0;
        if (!list_empty && (newest > last_base)) begin
          // fresh keepalive: restart timer, drop escalation
          last_act_d   = newest;
          reload_cnt_d = '0;
        end else if (quiet > TimeW'(limit)) begin
          // silence too long: escalate
          last_act_d = now;
          if (reload_inc == boot) begin
            reload_cnt_d = '0;
            action       = ACT_REBOOT;
          end else begin
            reload_cnt_d = reload_inc;
            action       = ACT_RELOAD;
          end
        end
      end
    end
  end

  // Advance state once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_act_q   <= '0;
      reload_cnt_q <= '0;
      hold_cnt_q   <= '0;
    end else if (advance) begin
      last_act_q   <= last_act_d;
      reload_cnt_q <= reload_cnt_d;
      hold_cnt_q   <= hold_cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {release_hold, action};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW-OutFieldsW)'(0), out_data_q};

`ifndef SYNTH
  // A hold release never comes with an escalation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[2] && (out_data_q[1:0] != ACT_NONE)))
    else $error("release_hold together with an action");

  // The action code stays within none, reload, reboot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[1:0] != 2'd3))
    else $error("invalid action code");

  // A reboot restarts the escalation count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (action == ACT_REBOOT)) |=> (reload_cnt_q == '0))
    else $error("reload count not cleared after reboot");

  // A clear request zeroes timer and count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && clear_req) |=> ((last_act_q == '0) && (reload_cnt_q == '0)))
    else $error("clear request did not reset the watchdog");
`endif

endmodule

`default_nettype wire
